// ----- rtl/pcc_pkg.sv -----
// Shared types, constants and helpers for the phase current conditioner.
// No dependencies; imported by every other file of the block.
package pcc_pkg;

   localparam int NPHASE      = 3;
   localparam int RAW_W       = 16;
   localparam int GAIN_W      = 18;
   localparam int PROD_W      = RAW_W + GAIN_W;
   localparam int SCALE_SHIFT = 8;
   localparam int SHR_W       = PROD_W - SCALE_SHIFT;
   localparam int CUR_W       = 24;
   localparam int LIM_W       = 23;
   localparam int SUM_W       = 32;
   localparam int WIDE_W      = 32;
   localparam int FLAG_W      = 3;

   // Offset calibration length, 2 to 256 items.
   localparam int CAL_SAMPLES = 128;
   localparam int CAL_CNT_W   = (CAL_SAMPLES > 2) ? $clog2(CAL_SAMPLES) : 1;
   // floor(log2(CAL_SAMPLES))
   localparam int CAL_SHIFT   = $clog2(CAL_SAMPLES + 1) - 1;
   localparam logic [CAL_CNT_W-1:0] CAL_LAST = CAL_CNT_W'(CAL_SAMPLES - 1);

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam logic [LIM_W-1:0] TRIP_LIMIT_RST = LIM_W'(64000);
   localparam logic [LIM_W-1:0] ZERO_BAND_RST  = LIM_W'(128);

   localparam logic signed [WIDE_W-1:0] CUR_MAX_WIDE = 32'sd8388607;
   localparam logic signed [WIDE_W-1:0] CUR_MIN_WIDE = -32'sd8388608;
   localparam logic signed [CUR_W-1:0]  CUR_MAX      = 24'sh7FFFFF;
   localparam logic signed [CUR_W-1:0]  CUR_MIN      = 24'sh800000;

   typedef enum logic [2:0] {
      REG_GAIN_A     = 3'd0,
      REG_GAIN_B     = 3'd1,
      REG_GAIN_C     = 3'd2,
      REG_TRIP_LIMIT = 3'd3,
      REG_ZERO_BAND  = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] gain_a;
      logic signed [GAIN_W-1:0] gain_b;
      logic signed [GAIN_W-1:0] gain_c;
      logic [LIM_W-1:0]         trip_limit;
      logic [LIM_W-1:0]         zero_band;
   } cfg_type;

   typedef struct packed {
      logic signed [CUR_W-1:0] cur;     // before deadband, after offset
      logic signed [CUR_W-1:0] shown;   // after deadband
      logic                    trip;
   } phase_res_type;

   // Saturate a sign-extended value to the signed current range.
   function automatic logic signed [CUR_W-1:0] sat_cur(input logic signed [WIDE_W-1:0] x);
      if (x > CUR_MAX_WIDE) begin
         return CUR_MAX;
      end else if (x < CUR_MIN_WIDE) begin
         return CUR_MIN;
      end else begin
         return x[CUR_W-1:0];
      end
   endfunction

endpackage

// ----- rtl/pcc_csr.sv -----
// Configuration register file: gains, trip limit and deadband.
// Depends on pcc_pkg.
module pcc_csr
   import pcc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_reg_type sel;
   logic        wr_en;

   assign sel        = csr_reg_type'(csr_paddr[CSR_AW-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (sel)
            REG_GAIN_A:     cfg_in.gain_a     = csr_pwdata[GAIN_W-1:0];
            REG_GAIN_B:     cfg_in.gain_b     = csr_pwdata[GAIN_W-1:0];
            REG_GAIN_C:     cfg_in.gain_c     = csr_pwdata[GAIN_W-1:0];
            REG_TRIP_LIMIT: cfg_in.trip_limit = csr_pwdata[LIM_W-1:0];
            REG_ZERO_BAND:  cfg_in.zero_band  = csr_pwdata[LIM_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (sel)
         REG_GAIN_A:     csr_prdata = CSR_DW'(cfg_ff.gain_a);
         REG_GAIN_B:     csr_prdata = CSR_DW'(cfg_ff.gain_b);
         REG_GAIN_C:     csr_prdata = CSR_DW'(cfg_ff.gain_c);
         REG_TRIP_LIMIT: csr_prdata = CSR_DW'(cfg_ff.trip_limit);
         REG_ZERO_BAND:  csr_prdata = CSR_DW'(cfg_ff.zero_band);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_a     <= '0;
         cfg_ff.gain_b     <= '0;
         cfg_ff.gain_c     <= '0;
         cfg_ff.trip_limit <= TRIP_LIMIT_RST;
         cfg_ff.zero_band  <= ZERO_BAND_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/pcc_scale.sv -----
// One phase of gain scaling: (raw * gain) >> 8, floor, saturated to 24 bits.
// Depends on pcc_pkg.
module pcc_scale
   import pcc_pkg::*;
(
   input  logic signed [RAW_W-1:0]  raw,
   input  logic signed [GAIN_W-1:0] gain,
   output logic signed [CUR_W-1:0]  scaled
);

   logic signed [PROD_W-1:0] prod;
   logic signed [SHR_W-1:0]  shr;

   assign prod   = raw * gain;
   assign shr    = prod[PROD_W-1:SCALE_SHIFT];   // arithmetic floor shift
   assign scaled = sat_cur(WIDE_W'(shr));

endmodule

// ----- rtl/pcc_condition.sv -----
// One phase of conditioning: offset removal, trip compare and deadband.
// Depends on pcc_pkg.
module pcc_condition
   import pcc_pkg::*;
(
   input  logic signed [CUR_W-1:0] scaled,
   input  logic signed [CUR_W-1:0] offset,
   input  logic [LIM_W-1:0]        trip_limit,
   input  logic [LIM_W-1:0]        zero_band,
   output phase_res_type           res
);

   logic signed [CUR_W:0]   diff;
   logic signed [CUR_W-1:0] cur;
   logic [CUR_W-1:0]        mag;

   assign diff = (CUR_W+1)'(scaled) - (CUR_W+1)'(offset);
   assign cur  = sat_cur(WIDE_W'(diff));
   // most negative value maps to 2^23, which still fits unsigned
   assign mag  = cur[CUR_W-1] ? (~cur + 1'b1) : cur;

   assign res.cur   = cur;
   assign res.trip  = mag > {1'b0, trip_limit};
   assign res.shown = (mag < {1'b0, zero_band}) ? '0 : cur;

endmodule

// ----- rtl/phase_current_conditioner_core.sv -----
// Three-phase current conditioner: gain scaling, power-up offset
// calibration, sticky overcurrent trip with capture, output deadband.
// Each input transfer passes through the scaled stage and the output stage;
// one item per cycle sustained while rsp_tready does not stall the output.
// Synchronous active-high reset: registers to defaults, offsets and sums
// zero, no trips, calibration restarts with the first item.
module phase_current_conditioner_core
   import pcc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // raw_a[15:0], raw_b[31:16], raw_c[47:32]
   input  logic [47:0]       req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // current_a[23:0], current_b[47:24], current_c[71:48], trip_flags[74:72],
   // trip_current_a[98:75], trip_current_b[122:99], trip_current_c[146:123],
   // zero pad [151:147]
   output logic [151:0]      rsp_tdata,
   // calibrating[0]
   output logic              rsp_tuser,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type cfg;

   pcc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // handshake
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_ready, s1_load, out_load;

   assign out_ready  = ~rsp_valid_ff | rsp_tready;
   assign req_tready = ~s1_valid_ff | out_ready;
   assign s1_load    = req_tvalid & req_tready;
   assign out_load   = s1_valid_ff & out_ready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      s1_valid_in  = s1_load ? 1'b1 : (out_ready ? 1'b0 : s1_valid_ff);
      rsp_valid_in = out_ready ? s1_valid_ff : rsp_valid_ff;
   end

   // calibration and trip state
   logic                    done_ff, done_in;
   logic [CAL_CNT_W-1:0]    count_ff, count_in;
   logic [FLAG_W-1:0]       fault_ff, fault_in;
   logic                    cal_ff;
   logic signed [CUR_W-1:0] offset_ff  [NPHASE];
   logic signed [CUR_W-1:0] offset_in  [NPHASE];
   logic signed [SUM_W-1:0] sum_ff     [NPHASE];
   logic signed [SUM_W-1:0] sum_in     [NPHASE];
   logic signed [CUR_W-1:0] capture_ff [NPHASE];
   logic signed [CUR_W-1:0] capture_in [NPHASE];
   logic signed [CUR_W-1:0] scaled_ff  [NPHASE];
   logic signed [CUR_W-1:0] scaled_in  [NPHASE];
   logic signed [CUR_W-1:0] shown_ff   [NPHASE];
   logic signed [GAIN_W-1:0] gain      [NPHASE];
   phase_res_type           res        [NPHASE];
   logic                    cal_end;

   assign gain[0] = cfg.gain_a;
   assign gain[1] = cfg.gain_b;
   assign gain[2] = cfg.gain_c;

   assign cal_end = ~done_ff & (count_ff == CAL_LAST);

   for (genvar p = 0; p < NPHASE; p++) begin : g_phase
      logic signed [CUR_W-1:0] off_used;
      logic signed [SUM_W-1:0] sum_next;

      pcc_scale u_scale (
         .raw    (req_tdata[p*RAW_W +: RAW_W]),
         .gain   (gain[p]),
         .scaled (scaled_in[p])
      );

      // offsets stay zero until calibration has finished
      assign off_used = done_ff ? offset_ff[p] : '0;

      pcc_condition u_cond (
         .scaled     (scaled_ff[p]),
         .offset     (off_used),
         .trip_limit (cfg.trip_limit),
         .zero_band  (cfg.zero_band),
         .res        (res[p])
      );

      assign sum_next      = sum_ff[p] + SUM_W'(res[p].cur);
      assign sum_in[p]     = (out_load & ~done_ff) ? sum_next : sum_ff[p];
      assign offset_in[p]  = (out_load & cal_end) ? sat_cur(sum_next >>> CAL_SHIFT)
                                                  : offset_ff[p];
      assign capture_in[p] = (out_load & res[p].trip) ? res[p].cur : capture_ff[p];
      assign fault_in[p]   = fault_ff[p] | (out_load & res[p].trip);
   end

   always_comb begin
      done_in  = done_ff;
      count_in = count_ff;
      if (out_load & ~done_ff) begin
         count_in = count_ff + 1'b1;
         if (cal_end) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
         count_ff     <= '0;
         fault_ff     <= '0;
         for (int i = 0; i < NPHASE; i++) begin
            offset_ff[i]  <= '0;
            sum_ff[i]     <= '0;
            capture_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
         count_ff     <= count_in;
         fault_ff     <= fault_in;
         for (int i = 0; i < NPHASE; i++) begin
            offset_ff[i]  <= offset_in[i];
            sum_ff[i]     <= sum_in[i];
            capture_ff[i] <= capture_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_load) begin
         for (int i = 0; i < NPHASE; i++) begin
            scaled_ff[i] <= scaled_in[i];
         end
      end
      if (out_load) begin
         cal_ff <= ~done_ff;
         for (int i = 0; i < NPHASE; i++) begin
            shown_ff[i] <= res[i].shown;
         end
      end
   end

   // trip flags and captures are the state itself, updated with each result
   assign rsp_tdata = {5'b0, capture_ff[2], capture_ff[1], capture_ff[0], fault_ff,
                       shown_ff[2], shown_ff[1], shown_ff[0]};
   assign rsp_tuser = cal_ff;

endmodule
